FILE: sv/bcn_pkg.sv
package bcn_pkg;

    // Default largest image side in texels.
    localparam int MAX_DIM_DEFAULT = 4096;

    // Compressed block formats, as written to the format register.
    typedef enum logic [1:0] {
        FMT_BC1  = 2'd0,
        FMT_BC2  = 2'd1,
        FMT_BC3  = 2'd2,
        FMT_RXGB = 2'd3
    } fmt_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // One decoded palette entry.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

endpackage

FILE: sv/bcn_texture_block_decoder.sv
// Channel     Direction  Handshake                      Payload
// s_axis      in         s_axis_tvalid / s_axis_tready  tdata: block_low, block_high
// m_axis      out        m_axis_tvalid / m_axis_tready  tdata: texel_x, texel_y, red, green,
//                                                        blue, alpha; tlast: last_texel
// cfg         in         cfg_we (no back-pressure)      cfg_index, cfg_data
//
// The texel sequencer walks the sixteen texels of the held block one per cycle while the
// output keeps pace, clipped ones included; a new block is accepted only once all sixteen
// are stepped. The first texel is registered out after the block registers capture it.
// Reset restores the format (BC1), width and height (4096) and sets the block
// position to the top-left block. A stall on the output freezes the sequencer; the
// next block is accepted in the same cycle as the last texel of the current one.
module bcn_texture_block_decoder #(
    parameter int MAX_DIM = bcn_pkg::MAX_DIM_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input block stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] block_low, [127:64] block_high
    // Output texel stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,   // [11:0] texel_x, [23:12] texel_y, [31:24] red,
                                         // [39:32] green, [47:40] blue, [55:48] alpha
    output logic         m_axis_tlast,   // last_texel
    // Configuration writes.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data
);
    import bcn_pkg::*;

    // Blocks along one side, counter width, and the widths needed to compare
    // texel coordinates against the clamped image size.
    localparam int BLK_MAX = (MAX_DIM + 3) / 4;
    localparam int CW      = (BLK_MAX > 1) ? $clog2(BLK_MAX) : 1;
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int EW      = (DW > 13) ? DW : 13;
    localparam int XW      = CW + 2;
    localparam int CMPW    = ((XW > EW) ? XW : EW) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    fmt_t        fmt_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_BC1;
            width_reg  <= 13'd4096;
            height_reg <= 13'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT: fmt_reg    <= fmt_t'(cfg_data[1:0]);
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Sizes above the maximum are clamped to it.
    logic [CMPW-1:0] w_eff;
    logic [CMPW-1:0] h_eff;
    logic [CMPW-1:0] w_blocks;
    logic [CMPW-1:0] h_blocks;

    always_comb
    begin
        w_eff = (CMPW'(width_reg) > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : CMPW'(width_reg);
        h_eff = (CMPW'(height_reg) > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : CMPW'(height_reg);
        // A zero size still counts as one block along that axis.
        w_blocks = (w_eff == '0) ? CMPW'(1) : ((w_eff + CMPW'(3)) >> 2);
        h_blocks = (h_eff == '0) ? CMPW'(1) : ((h_eff + CMPW'(3)) >> 2);
    end

    // ------------------------------------------------------------------
    // Handshake and sequencing control
    // ------------------------------------------------------------------
    logic         blk_valid_reg;
    logic [3:0]   texel_cnt_reg;
    logic         out_valid_reg;
    logic         out_free;
    logic         step;
    logic         blk_done;
    logic         accept;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = blk_valid_reg && out_free;
    assign blk_done      = step && (texel_cnt_reg == 4'hF);
    assign s_axis_tready = !blk_valid_reg || blk_done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Block position counters, advanced on every accepted block
    // ------------------------------------------------------------------
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   row_reg;
    logic [CW-1:0]   col_next;
    logic [CW-1:0]   row_next;
    logic [CMPW-1:0] col_plus;
    logic [CMPW-1:0] row_plus;

    always_comb
    begin
        col_plus = CMPW'(col_reg) + CMPW'(1);
        row_plus = CMPW'(row_reg) + CMPW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_plus >= w_blocks)
            begin
                col_next = '0;
                row_next = (row_plus >= h_blocks) ? '0 : CW'(row_plus);
            end
            else
            begin
                col_next = CW'(col_plus);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Which of the four columns and rows of the incoming block lie in the image.
    logic [3:0]  col_ok;
    logic [3:0]  row_ok;
    logic [15:0] emit_mask_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            col_ok[i] = CMPW'({col_reg, 2'(i)}) < w_eff;
            row_ok[i] = CMPW'({row_reg, 2'(i)}) < h_eff;
        end
        for (int i = 0; i < 16; i++)
        begin
            emit_mask_next[i] = row_ok[i / 4] && col_ok[i % 4];
        end
    end

    // ------------------------------------------------------------------
    // Palette build on the incoming block, held with the block
    // ------------------------------------------------------------------
    rgba_t [3:0]      colour_pal;
    logic [7:0][7:0]  alpha_pal;

    bcn_palette u_palette (
        .block_format (fmt_reg),
        .block_low    (s_axis_tdata[63:0]),
        .block_high   (s_axis_tdata[127:64]),
        .colour_pal   (colour_pal),
        .alpha_pal    (alpha_pal)
    );

    rgba_t [3:0]      colour_pal_reg;
    logic [7:0][7:0]  alpha_pal_reg;
    logic [31:0]      cidx_reg;
    logic [63:0]      alpha_bits_reg;
    logic [15:0]      emit_mask_reg;
    logic [CW-1:0]    col_base_reg;
    logic [CW-1:0]    row_base_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            colour_pal_reg <= colour_pal;
            alpha_pal_reg  <= alpha_pal;
            cidx_reg       <= (fmt_reg == FMT_BC1) ? s_axis_tdata[63:32]
                                                   : s_axis_tdata[127:96];
            alpha_bits_reg <= s_axis_tdata[63:0];
            emit_mask_reg  <= emit_mask_next;
            col_base_reg   <= col_reg;
            row_base_reg   <= row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            texel_cnt_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                blk_valid_reg <= 1'b1;
                texel_cnt_reg <= '0;
            end
            else
            begin
                if (blk_done)
                begin
                    blk_valid_reg <= 1'b0;
                end
                if (step)
                begin
                    texel_cnt_reg <= texel_cnt_reg + 4'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-texel selection into the output register
    // ------------------------------------------------------------------
    logic        emit;
    logic [1:0]  csel;
    logic [3:0]  nibble;
    logic [5:0]  aoff;
    logic [2:0]  asel;
    rgba_t       texel;
    rgba_t       texel_next;
    logic        last_next;

    always_comb
    begin
        emit   = step && emit_mask_reg[texel_cnt_reg];
        csel   = cidx_reg[{texel_cnt_reg, 1'b0} +: 2];
        nibble = alpha_bits_reg[{texel_cnt_reg, 2'b00} +: 4];
        aoff   = 6'd16 + {1'b0, texel_cnt_reg, 1'b0} + {2'b00, texel_cnt_reg};
        asel   = alpha_bits_reg[aoff +: 3];
        texel  = colour_pal_reg[csel];

        texel_next = texel;
        case (fmt_reg)
            FMT_BC1:  texel_next = texel;
            // A nibble times 17 is the nibble repeated.
            FMT_BC2:  texel_next.a = {nibble, nibble};
            FMT_BC3:  texel_next.a = alpha_pal_reg[asel];
            FMT_RXGB:
            begin
                texel_next.r = alpha_pal_reg[asel];
                texel_next.a = texel.r;
            end
            default:  texel_next = texel;
        endcase

        // The last emitted texel is the highest set bit of the emit mask.
        last_next = (emit_mask_reg >> texel_cnt_reg) == 16'd1;
    end

    logic [11:0] out_x_reg;
    logic [11:0] out_y_reg;
    rgba_t       out_texel_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg     <= 12'({col_base_reg, texel_cnt_reg[1:0]});
            out_y_reg     <= 12'({row_base_reg, texel_cnt_reg[3:2]});
            out_texel_reg <= texel_next;
            out_last_reg  <= last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_texel_reg.a, out_texel_reg.b, out_texel_reg.g,
                            out_texel_reg.r, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted block starts its walk at the first texel.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> blk_valid_reg && (texel_cnt_reg == 4'd0))
        else $error("accepted block did not start at texel zero");

    // A texel only appears while a block is being walked.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(blk_valid_reg))
        else $error("texel emitted with no block held");

    // The block position never leaves the largest image.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CMPW'(col_reg) < CMPW'(BLK_MAX)) && (CMPW'(row_reg) < CMPW'(BLK_MAX)))
        else $error("block position out of range");

endmodule

FILE: sv/bcn_palette.sv
// Builds the colour and alpha palettes of one compressed block.
module bcn_palette (
    input  bcn_pkg::fmt_t            block_format,
    input  logic [63:0]              block_low,
    input  logic [63:0]              block_high,
    output bcn_pkg::rgba_t [3:0]     colour_pal,
    output logic [7:0][7:0]          alpha_pal
);
    import bcn_pkg::*;

    // floor(x / 3) for x up to 765, by reciprocal multiplication.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = {10'd0, x} * 20'd683;
        return p[18:11];
    endfunction

    // floor(x / 5) for x up to 1275.
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = {12'd0, x} * 23'd3277;
        return p[21:14];
    endfunction

    // floor(x / 7) for x up to 1785.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = {12'd0, x} * 23'd2341;
        return p[21:14];
    endfunction

    function automatic rgba_t expand565(input logic [15:0] c);
        rgba_t e;
        e.r = {c[15:11], c[15:13]};
        e.g = {c[10:5], c[10:9]};
        e.b = {c[4:0], c[4:2]};
        e.a = 8'd255;
        return e;
    endfunction

    // (2a + b) / 3
    function automatic logic [7:0] mix_third(input logic [7:0] a, input logic [7:0] b);
        return div3({1'b0, a, 1'b0} + {2'b00, b});
    endfunction

    function automatic logic [7:0] mix_half(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    logic [63:0] colour_half;
    logic [15:0] c0;
    logic [15:0] c1;
    rgba_t       e0;
    rgba_t       e1;
    logic        four_colour;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [10:0] wsum;

    always_comb
    begin
        colour_half = (block_format == FMT_BC1) ? block_low : block_high;
        c0          = colour_half[15:0];
        c1          = colour_half[31:16];
        e0          = expand565(c0);
        e1          = expand565(c1);
        // Only BC1 has the three-colour mode with transparent black.
        four_colour = (block_format != FMT_BC1) || (c0 > c1);

        colour_pal[0] = e0;
        colour_pal[1] = e1;
        if (four_colour)
        begin
            colour_pal[2].r = mix_third(e0.r, e1.r);
            colour_pal[2].g = mix_third(e0.g, e1.g);
            colour_pal[2].b = mix_third(e0.b, e1.b);
            colour_pal[2].a = 8'd255;
            colour_pal[3].r = mix_third(e1.r, e0.r);
            colour_pal[3].g = mix_third(e1.g, e0.g);
            colour_pal[3].b = mix_third(e1.b, e0.b);
            colour_pal[3].a = 8'd255;
        end
        else
        begin
            colour_pal[2].r = mix_half(e0.r, e1.r);
            colour_pal[2].g = mix_half(e0.g, e1.g);
            colour_pal[2].b = mix_half(e0.b, e1.b);
            colour_pal[2].a = 8'd255;
            colour_pal[3]   = '0;
        end

        a0           = block_low[7:0];
        a1           = block_low[15:8];
        alpha_pal[0] = a0;
        alpha_pal[1] = a1;
        wsum         = '0;
        if (a0 > a1)
        begin
            // Six interpolated steps, weights (7-s, s) over 7.
            for (int s = 1; s <= 6; s++)
            begin
                wsum = 11'(7 - s) * {3'b000, a0} + 11'(s) * {3'b000, a1};
                alpha_pal[1 + s] = div7(wsum);
            end
        end
        else
        begin
            // Four interpolated steps, then fully transparent and fully opaque.
            for (int s = 1; s <= 4; s++)
            begin
                wsum = 11'(5 - s) * {3'b000, a0} + 11'(s) * {3'b000, a1};
                alpha_pal[1 + s] = div5(wsum);
            end
            alpha_pal[6] = 8'd0;
            alpha_pal[7] = 8'd255;
        end
    end

endmodule

FILE: dv/bcn_texture_block_decoder_checker.sv
`timescale 1ns / 100ps

// Watches the block and texel streams and the register port. It keeps its own copy
// of the format, the image size and the block position, and decodes every accepted
// block into the texels it should emit. Each emitted texel is then compared with the
// oldest of these.
module bcn_texture_block_decoder_checker #(
    parameter int MAX_DIM = bcn_pkg::MAX_DIM_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] block_low, [127:64] block_high
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [55:0]  m_axis_tdata,   // [11:0] texel_x, [23:12] texel_y, [31:24] red,
                                         // [39:32] green, [47:40] blue, [55:48] alpha
    input  logic         m_axis_tlast,   // last_texel
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data,
    output int           mismatch_count,
    output int           texels_awaited
);
    import bcn_pkg::*;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        rgba_t       px;
        logic        last;
    } texel_t;

    texel_t      expected_texels[$];
    fmt_t        fmt;
    logic [12:0] img_w;
    logic [12:0] img_h;
    int unsigned blk_col;
    int unsigned blk_row;

    initial
    begin
        mismatch_count = 0;
        texels_awaited = 0;
    end

    function automatic int unsigned clamp_dim(logic [12:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    // A zero dimension still counts as one block along that axis.
    function automatic int unsigned blocks_along(int unsigned dim);
        int unsigned n;
        n = (dim + 3) / 4;
        return (n == 0) ? 1 : n;
    endfunction

    function automatic rgba_t expand_565(logic [15:0] c);
        rgba_t e;
        e.r = {c[15:11], c[15:13]};
        e.g = {c[10:5], c[10:9]};
        e.b = {c[4:0], c[4:2]};
        e.a = 8'hFF;
        return e;
    endfunction

    function automatic logic [7:0] blend(int unsigned p, int unsigned q, int unsigned wp,
                                         int unsigned wq, int unsigned div);
        return 8'((wp * p + wq * q) / div);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: texel %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic decode_block(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] colour;
        rgba_t       pal[4];
        logic [7:0]  apal[8];
        logic [7:0]  swap;
        texel_t      tx;
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int          last_t;
        colour = (fmt == FMT_BC1) ? lo : hi;
        w = clamp_dim(img_w);
        h = clamp_dim(img_h);

        pal[0] = expand_565(colour[15:0]);
        pal[1] = expand_565(colour[31:16]);
        // Only BC1 drops into the three-colour mode with transparent black.
        if (colour[15:0] > colour[31:16] || fmt != FMT_BC1)
        begin
            pal[2].r = blend(pal[0].r, pal[1].r, 2, 1, 3);
            pal[2].g = blend(pal[0].g, pal[1].g, 2, 1, 3);
            pal[2].b = blend(pal[0].b, pal[1].b, 2, 1, 3);
            pal[3].r = blend(pal[0].r, pal[1].r, 1, 2, 3);
            pal[3].g = blend(pal[0].g, pal[1].g, 1, 2, 3);
            pal[3].b = blend(pal[0].b, pal[1].b, 1, 2, 3);
            pal[3].a = 8'hFF;
        end
        else
        begin
            pal[2].r = blend(pal[0].r, pal[1].r, 1, 1, 2);
            pal[2].g = blend(pal[0].g, pal[1].g, 1, 1, 2);
            pal[2].b = blend(pal[0].b, pal[1].b, 1, 1, 2);
            pal[3] = '0;
        end
        pal[2].a = 8'hFF;

        apal[0] = lo[7:0];
        apal[1] = lo[15:8];
        if (lo[7:0] > lo[15:8])
        begin
            for (int s = 1; s <= 6; s++)
                apal[1 + s] = blend(lo[7:0], lo[15:8], 7 - s, s, 7);
        end
        else
        begin
            for (int s = 1; s <= 4; s++)
                apal[1 + s] = blend(lo[7:0], lo[15:8], 5 - s, s, 5);
            apal[6] = 8'h00;
            apal[7] = 8'hFF;
        end

        last_t = -1;
        for (int t = 0; t < 16; t++)
            if (blk_col * 4 + t % 4 < w && blk_row * 4 + t / 4 < h)
                last_t = t;

        for (int t = 0; t < 16; t++)
        begin
            x = blk_col * 4 + t % 4;
            y = blk_row * 4 + t / 4;
            if (x < w && y < h)
            begin
                tx.px = pal[colour[32 + 2 * t +: 2]];
                if (fmt == FMT_BC2)
                    tx.px.a = 8'(lo[4 * t +: 4] * 17);
                else if (fmt == FMT_BC3 || fmt == FMT_RXGB)
                    tx.px.a = apal[lo[16 + 3 * t +: 3]];
                if (fmt == FMT_RXGB)
                begin
                    swap = tx.px.r;
                    tx.px.r = tx.px.a;
                    tx.px.a = swap;
                end
                tx.x = x[11:0];
                tx.y = y[11:0];
                tx.last = (t == last_t);
                expected_texels.push_back(tx);
            end
        end

        // The position moves on even when every texel was clipped.
        blk_col++;
        if (blk_col >= blocks_along(w))
        begin
            blk_col = 0;
            blk_row++;
            if (blk_row >= blocks_along(h))
                blk_row = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        texel_t want;
        if (!rst_n)
        begin
            fmt = FMT_BC1;
            img_w = 13'd4096;
            img_h = 13'd4096;
            blk_col = 0;
            blk_row = 0;
            expected_texels.delete();
            texels_awaited = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_texels.size() == 0)
                begin
                    $display("%0t: unexpected texel, expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_texels.pop_front();
                    check_field("x", want.x, m_axis_tdata[11:0]);
                    check_field("y", want.y, m_axis_tdata[23:12]);
                    check_field("red", want.px.r, m_axis_tdata[31:24]);
                    check_field("green", want.px.g, m_axis_tdata[39:32]);
                    check_field("blue", want.px.b, m_axis_tdata[47:40]);
                    check_field("alpha", want.px.a, m_axis_tdata[55:48]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_block(s_axis_tdata[63:0], s_axis_tdata[127:64]);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FORMAT: fmt = fmt_t'(cfg_data[1:0]);
                    REG_WIDTH:  img_w = cfg_data;
                    REG_HEIGHT: img_h = cfg_data;
                    default: ;
                endcase
            end
            texels_awaited = expected_texels.size();
        end
    end

endmodule

FILE: dv/bcn_texture_block_decoder_tb.sv
`timescale 1ns / 100ps

// Top of the decoder bench. This module only makes stimulus and gives the verdict;
// all prediction and comparison lives in the checker instantiated beside the block.
module bcn_texture_block_decoder_tb;

    import bcn_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // [63:0] block_low, [127:64] block_high
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;   // [11:0] texel_x, [23:12] texel_y, [31:24] red,
                                  // [39:32] green, [47:40] blue, [55:48] alpha
    logic         m_axis_tlast;   // last_texel
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [12:0]  cfg_data;

    int mismatch_count;
    int texels_awaited;

    // When set, neither side inserts idle cycles any more.
    bit steady;

    // Random phases: each one sets the format and the image size, then sends nine
    // blocks. The sizes cover one texel, partial blocks, the zero-size case on each
    // axis, the full 4096 and values above it, which the block treats as 4096.
    localparam int NUM_PHASES = 11;
    localparam int ITEMS_PER_PHASE = 9;
    fmt_t        phase_fmt[NUM_PHASES] = '{FMT_BC1, FMT_BC2, FMT_BC3, FMT_RXGB, FMT_BC1,
                                           FMT_BC2, FMT_BC3, FMT_RXGB, FMT_BC1, FMT_BC3,
                                           FMT_BC2};
    logic [12:0] phase_w[NUM_PHASES] = '{1, 3, 5, 13, 0, 4096, 7, 4097, 6, 9, 8};
    logic [12:0] phase_h[NUM_PHASES] = '{1, 7, 5, 2, 9, 1, 0, 6, 8191, 4096, 8};

    // Directed blocks, sent at the reset settings (BC1, 4096 x 4096) and then with
    // the format switched to BC2 at item 5, BC3 at item 8 and RXGB at item 12.
    localparam int NUM_DIRECTED = 15;
    logic [63:0] dir_lo[NUM_DIRECTED] = '{
        64'hE4E4E4E4_0000_FFFF,   // BC1 four-colour mode, every index value
        64'h1B1B1B1B_F800_001F,   // BC1 c0 < c1: three-colour mode
        64'hFFFFFFFF_7BEF_7BEF,   // BC1 equal endpoints: all transparent black
        64'h0,
        64'hFFFFFFFF_FFFFFFFF,
        64'hFEDCBA98_76543210,    // BC2 every explicit alpha value
        64'hFFFFFFFF_FFFFFFFF,
        64'h0,
        64'hFAC688FAC688_00_FF,   // BC3 a0 > a1: eight-value alpha
        64'hFAC688FAC688_FF_00,   // BC3 a0 < a1: six values plus 0 and 255
        64'hFAC688FAC688_80_80,   // BC3 equal alpha endpoints
        64'hFFFFFFFF_FFFFFFFF,
        64'hFAC688FAC688_00_FF,   // RXGB, red and alpha swapped
        64'hFAC688FAC688_FF_00,
        64'h0
    };
    logic [63:0] dir_hi[NUM_DIRECTED] = '{
        64'h0123456789ABCDEF,
        64'h0,
        64'hFFFFFFFF_FFFFFFFF,
        64'hFFFFFFFF_FFFFFFFF,
        64'hFFFFFFFF_FFFFFFFF,
        64'hE4E4E4E4_FFFF_0000,   // BC2 with c0 < c1 still uses four colours
        64'h0,
        64'hFFFFFFFF_FFFFFFFF,
        64'h1B1B1B1B_F800_07E0,
        64'hE4E4E4E4_001F_FFFF,
        64'hFFFFFFFF_7BEF_7BEF,
        64'hFFFFFFFF_FFFFFFFF,
        64'hE4E4E4E4_F81F_07E0,
        64'h1B1B1B1B_0000_FFFF,
        64'h0
    };

    bcn_texture_block_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bcn_texture_block_decoder_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .texels_awaited (texels_awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The run normally takes well under a millisecond of simulated time, so a hang
    // anywhere in the handshakes ends up here.
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Texel back-pressure: ready is held high or low for random stretches, the high ones
    // now and then long. Once the run turns steady it stays high. Exactly one assignment
    // per falling edge.
    initial
    begin
        int unsigned span;
        m_axis_tready = 1'b0;
        forever
        begin
            if (steady)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                span = $urandom_range(1, 13);
                repeat (span)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
            else
            begin
                span = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 20);
                repeat (span)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Offers one block and returns at the rising edge where it is taken. Before the
    // offer the sender may first sit idle with valid low; otherwise valid simply stays
    // high from the previous block.
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
        int unsigned gap;
        @(negedge clk);
        if (!steady && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {hi, lo};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Lowers valid and waits until every predicted texel is out. A fully clipped block
    // emits nothing yet still keeps the sequencer busy while it walks all sixteen texels, so
    // a margin follows before the block counts as idle.
    task automatic drain_texels();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (texels_awaited != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Rewrites all three registers on consecutive cycles while the block is idle.
    task automatic apply_settings(input fmt_t f, input logic [12:0] w, input logic [12:0] h);
        drain_texels();
        cfg_we <= 1'b1;
        cfg_index <= REG_FORMAT;
        cfg_data <= 13'(f);
        @(negedge clk);
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random block content. Some blocks get equal colour or alpha endpoints, or are
    // all zeros or all ones, so that the endpoint comparisons are hit often.
    task automatic make_block(output logic [63:0] lo, output logic [63:0] hi);
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:
            begin
                lo[31:16] = lo[15:0];
                hi[31:16] = hi[15:0];
            end
            1: lo[15:8] = lo[7:0];
            2:
            begin
                lo = {64{lo[0]}};
                hi = {64{hi[0]}};
            end
            default: ;
        endcase
    endtask

    task automatic send_random(input int count);
        logic [63:0] lo;
        logic [63:0] hi;
        repeat (count)
        begin
            make_block(lo, hi);
            send_block(lo, hi);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_FORMAT;
        cfg_data = '0;
        steady = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed blocks, all inside the 4096 x 4096 image, walking along row 0.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (i == 5)
                apply_settings(FMT_BC2, 13'd4096, 13'd4096);
            else if (i == 8)
                apply_settings(FMT_BC3, 13'd4096, 13'd4096);
            else if (i == 12)
                apply_settings(FMT_RXGB, 13'd4096, 13'd4096);
            send_block(dir_lo[i], dir_hi[i]);
        end

        // Random phases. Settings change while the position is mid-image, so counters
        // beyond the new block count wrap at their next advance. The last phase runs
        // with no idling on either side.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            apply_settings(phase_fmt[p], phase_w[p], phase_h[p]);
            if (p == NUM_PHASES - 1)
                steady = 1'b1;
            send_random(ITEMS_PER_PHASE);
        end

        drain_texels();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
